### rtl/hkrv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hybrid key record validator: shared package
// Record layout offsets, error codes, register indexes and common types.
// ----------------------------------------------------------------------------
package hkrv_pkg;

    // Record layout
    localparam int CLASSIC_KEY_BYTES = 32;
    localparam int ROOT_PQ_BYTES     = 1952;
    localparam int DEVICE_PQ_BYTES   = 1312;

    localparam int OFF_ROOT_CL   = 2;
    localparam int OFF_ROOT_PQ   = OFF_ROOT_CL + CLASSIC_KEY_BYTES;
    localparam int OFF_DEV_SUITE = OFF_ROOT_PQ + ROOT_PQ_BYTES;
    localparam int OFF_DEV_CL    = OFF_DEV_SUITE + 1;
    localparam int OFF_DEV_PQ    = OFF_DEV_CL + CLASSIC_KEY_BYTES;
    localparam int RECORD_LEN    = OFF_DEV_PQ + DEVICE_PQ_BYTES;

    // Position counter holds 0 .. RECORD_LEN + 1 (saturated two past the last byte)
    localparam int POS_W     = $clog2(RECORD_LEN + 2);
    localparam int KEY_IDX_W = (CLASSIC_KEY_BYTES > 1) ? $clog2(CLASSIC_KEY_BYTES) : 1;

    localparam logic [POS_W-1:0] POS_VERSION   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ROOT_ALG  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_ROOT_CL   = POS_W'(OFF_ROOT_CL);
    localparam logic [POS_W-1:0] POS_ROOT_PQ   = POS_W'(OFF_ROOT_PQ);
    localparam logic [POS_W-1:0] POS_DEV_SUITE = POS_W'(OFF_DEV_SUITE);
    localparam logic [POS_W-1:0] POS_DEV_CL    = POS_W'(OFF_DEV_CL);
    localparam logic [POS_W-1:0] POS_DEV_PQ    = POS_W'(OFF_DEV_PQ);
    localparam logic [POS_W-1:0] POS_END       = POS_W'(RECORD_LEN);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(RECORD_LEN - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VERSION     = 2'd0,
        REG_ROOT_ALG    = 2'd1,
        REG_DEV_SUITE   = 2'd2
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_VERSION    = 8'd2;
    localparam logic [7:0] RST_ROOT_ALG   = 8'd1;
    localparam logic [7:0] RST_DEV_SUITE  = 8'd1;

    // Verdict codes, lowest applicable one wins
    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_LENGTH       = 4'd1,
        ERR_VERSION      = 4'd2,
        ERR_ROOT_ALG     = 4'd3,
        ERR_DEV_SUITE    = 4'd4,
        ERR_ROOT_CL_ZERO = 4'd5,
        ERR_ROOT_PQ_ZERO = 4'd6,
        ERR_DEV_CL_ZERO  = 4'd7,
        ERR_DEV_PQ_ZERO  = 4'd8,
        ERR_KEYS_EQUAL   = 4'd9
    } err_code_t;

    // Expected header values
    typedef struct packed {
        logic [7:0] version;
        logic [7:0] root_alg;
        logic [7:0] dev_suite;
    } hkrv_cfg_t;

endpackage

### rtl/hybrid_key_record_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hybrid key record validator
// Checks a byte-serial key-authorization record and gives one verdict per
// record on its last byte.
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall  data_byte, end_of_record
//   output   out        out_valid / out_stall record_ok, error_code
//   config   in         cfg_write            cfg_index, cfg_data
//
// One byte is taken every cycle while in_stall is low. A byte is registered
// when accepted and checked from the input register; the verdict of a last
// byte is loaded into the result register once that register has room, and
// is held there on the output. Reset clears the position, the flags and both
// pipeline valids and loads the default header values. A stalled verdict only
// holds back a following last byte; other bytes keep flowing behind it.
// ----------------------------------------------------------------------------
module hybrid_key_record_validator_unit
    import hkrv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_record,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 record_ok,
    output logic [3:0]           error_code,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    hkrv_cfg_t  cfg_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    logic       out_ok_reg;
    err_code_t  out_code_reg;
    logic       out_free;
    logic       s1_go;
    err_code_t  verdict;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.version   <= RST_VERSION;
            cfg_reg.root_alg  <= RST_ROOT_ALG;
            cfg_reg.dev_suite <= RST_DEV_SUITE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VERSION:   cfg_reg.version   <= cfg_data;
                REG_ROOT_ALG:  cfg_reg.root_alg  <= cfg_data;
                REG_DEV_SUITE: cfg_reg.dev_suite <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Handshake: a last byte waits only for room in the result register
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_go    = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_stall = s1_valid_reg && !s1_go;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= end_of_record;
        end
    end

    hkrv_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .step          (s1_go),
        .data_byte     (s1_byte_reg),
        .end_of_record (s1_last_reg),
        .verdict       (verdict)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            out_ok_reg   <= (verdict == ERR_NONE);
            out_code_reg <= verdict;
        end
    end

    assign out_valid  = out_valid_reg;
    assign record_ok  = out_ok_reg;
    assign error_code = out_code_reg;

endmodule

### rtl/hkrv_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hybrid key record validator: record checker
// Tracks the byte position, header errors, nonzero region flags and the
// classical key comparison, and forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module hkrv_core
    import hkrv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hkrv_cfg_t  cfg,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       end_of_record,
    output err_code_t  verdict
);

    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [3:0]           flags_reg;
    logic [3:0]           flags_next;
    logic                 differ_reg;
    logic                 differ_next;
    err_code_t            hdr_err_reg;
    err_code_t            hdr_err_next;
    logic [7:0]           root_key_mem [CLASSIC_KEY_BYTES];

    logic                 is_version;
    logic                 is_root_alg;
    logic                 in_root_cl;
    logic                 in_root_pq;
    logic                 is_dev_suite;
    logic                 in_dev_cl;
    logic                 in_dev_pq;
    logic                 byte_nonzero;
    logic [POS_W-1:0]     root_off;
    logic [POS_W-1:0]     dev_off;
    logic [KEY_IDX_W-1:0] root_idx;
    logic [KEY_IDX_W-1:0] dev_idx;
    logic [7:0]           stored_byte;

    // Decode the region of the current position
    always_comb
    begin
        is_version    = (pos_reg == POS_VERSION);
        is_root_alg   = (pos_reg == POS_ROOT_ALG);
        in_root_cl    = (pos_reg >= POS_ROOT_CL) && (pos_reg < POS_ROOT_PQ);
        in_root_pq    = (pos_reg >= POS_ROOT_PQ) && (pos_reg < POS_DEV_SUITE);
        is_dev_suite  = (pos_reg == POS_DEV_SUITE);
        in_dev_cl     = (pos_reg >= POS_DEV_CL) && (pos_reg < POS_DEV_PQ);
        in_dev_pq     = (pos_reg >= POS_DEV_PQ) && (pos_reg < POS_END);
        byte_nonzero  = (data_byte != 8'd0);
        root_off      = pos_reg - POS_ROOT_CL;
        dev_off       = pos_reg - POS_DEV_CL;
        root_idx      = root_off[KEY_IDX_W-1:0];
        dev_idx       = dev_off[KEY_IDX_W-1:0];
        stored_byte   = root_key_mem[dev_idx];
    end

    // Update flags with the current byte
    always_comb
    begin
        hdr_err_next = hdr_err_reg;
        if (hdr_err_reg == ERR_NONE)
        begin
            if (is_version && (data_byte != cfg.version))
                hdr_err_next = ERR_VERSION;
            else if (is_root_alg && (data_byte != cfg.root_alg))
                hdr_err_next = ERR_ROOT_ALG;
            else if (is_dev_suite && (data_byte != cfg.dev_suite))
                hdr_err_next = ERR_DEV_SUITE;
        end

        flags_next    = flags_reg;
        flags_next[0] = flags_reg[0] | (in_root_cl & byte_nonzero);
        flags_next[1] = flags_reg[1] | (in_root_pq & byte_nonzero);
        flags_next[2] = flags_reg[2] | (in_dev_cl & byte_nonzero);
        flags_next[3] = flags_reg[3] | (in_dev_pq & byte_nonzero);

        differ_next = differ_reg | (in_dev_cl & (data_byte != stored_byte));
    end

    // Form the verdict from the updated state
    always_comb
    begin
        priority if (pos_reg != POS_LAST)
            verdict = ERR_LENGTH;
        else if (hdr_err_next != ERR_NONE)
            verdict = hdr_err_next;
        else if (!flags_next[0])
            verdict = ERR_ROOT_CL_ZERO;
        else if (!flags_next[1])
            verdict = ERR_ROOT_PQ_ZERO;
        else if (!flags_next[2])
            verdict = ERR_DEV_CL_ZERO;
        else if (!flags_next[3])
            verdict = ERR_DEV_PQ_ZERO;
        else if (!differ_next)
            verdict = ERR_KEYS_EQUAL;
        else
            verdict = ERR_NONE;
    end

    // Advance the position, saturating two past the last byte of the record
    always_comb
    begin
        if (pos_reg <= POS_END)
            pos_next = pos_reg + POS_W'(1);
        else
            pos_next = pos_reg;
    end

    // Hold record state; re-arm after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            flags_reg   <= '0;
            differ_reg  <= 1'b0;
            hdr_err_reg <= ERR_NONE;
        end
        else if (step)
        begin
            if (end_of_record)
            begin
                pos_reg     <= '0;
                flags_reg   <= '0;
                differ_reg  <= 1'b0;
                hdr_err_reg <= ERR_NONE;
            end
            else
            begin
                pos_reg     <= pos_next;
                flags_reg   <= flags_next;
                differ_reg  <= differ_next;
                hdr_err_reg <= hdr_err_next;
            end
        end
    end

    // Store the root classical key for the later comparison
    always_ff @(posedge clk)
    begin
        if (step && in_root_cl)
            root_key_mem[root_idx] <= data_byte;
    end

endmodule

### sim/hybrid_key_record_validator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hybrid key record validator: unit test
// Streams byte-serial key records into the validator and predicts each verdict
// from its own copy of the position counter, region flags, stored root key and
// header registers. Directed records cover each verdict code, the code
// priority, short and overrunning records and the header registers at their
// extremes. Random records then follow under three idling regimes: full-length
// records with random faults, mixed with short and near-length noise.
// ----------------------------------------------------------------------------
module hybrid_key_record_validator_unit_test;
    import hkrv_pkg::*;

    // Slowest correct run: about 190k bytes, slowed most
    // when heavy sender idling and stalled verdicts holding back last bytes add up
    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int SETTLE_CYCLES = 4;
    // Long enough for a 12-bit position that wraps to reach the last offset again
    localparam int OVERRUN_LEN   = 4096 + RECORD_LEN;
    // Index that the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic      ok;
        err_code_t code;
    } verdict_t;

    // Faults to build into one record
    typedef struct packed {
        logic       bad_version;
        logic       bad_root_alg;
        logic       bad_dev_suite;
        logic [3:0] zero_region;
        logic       keys_equal;
        logic       sparse;
    } rec_shape_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte     = 8'h00;
    logic                 end_of_record = 1'b0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic                 record_ok;
    logic [3:0]           error_code;
    logic                 cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [7:0]           cfg_data      = 8'h00;

    // Predicted state of the block
    hkrv_cfg_t   hdr_cfg;
    int unsigned rec_pos;
    logic [7:0]  root_key_copy [CLASSIC_KEY_BYTES];
    logic [3:0]  region_seen;
    logic        keys_differ;
    err_code_t   hdr_err;

    verdict_t    expected_verdicts [$];
    logic [7:0]  rec_bytes [$];

    int          send_idle_pct    = 0;
    int          recv_idle_pct    = 0;
    int          fail_count       = 0;
    int          verdicts_checked = 0;
    int          records_sent     = 0;
    int          full_records     = 0;
    int          cfg_writes       = 0;
    longint      bytes_sent       = 0;
    int          cycle_count      = 0;

    hybrid_key_record_validator_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .end_of_record (end_of_record),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .record_ok     (record_ok),
        .error_code    (error_code),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= 50)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Advance the predicted state by one accepted byte; queue a verdict on a last byte
    function automatic void judge_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        verdict_t    v;
        pos = rec_pos;
        if (pos == 0)
        begin
            if (b != hdr_cfg.version && hdr_err == ERR_NONE)
                hdr_err = ERR_VERSION;
        end
        else if (pos == 1)
        begin
            if (b != hdr_cfg.root_alg && hdr_err == ERR_NONE)
                hdr_err = ERR_ROOT_ALG;
        end
        else if (pos < OFF_ROOT_PQ)
        begin
            root_key_copy[pos - OFF_ROOT_CL] = b;
            if (b != 8'h00)
                region_seen[0] = 1'b1;
        end
        else if (pos < OFF_DEV_SUITE)
        begin
            if (b != 8'h00)
                region_seen[1] = 1'b1;
        end
        else if (pos == OFF_DEV_SUITE)
        begin
            if (b != hdr_cfg.dev_suite && hdr_err == ERR_NONE)
                hdr_err = ERR_DEV_SUITE;
        end
        else if (pos < OFF_DEV_PQ)
        begin
            if (b != root_key_copy[pos - OFF_DEV_CL])
                keys_differ = 1'b1;
            if (b != 8'h00)
                region_seen[2] = 1'b1;
        end
        else if (pos < RECORD_LEN)
        begin
            if (b != 8'h00)
                region_seen[3] = 1'b1;
        end

        // Saturate two past the last byte of the record
        if (rec_pos <= RECORD_LEN)
            rec_pos = pos + 1;

        if (last)
        begin
            if (pos != RECORD_LEN - 1)
                v.code = ERR_LENGTH;
            else if (hdr_err != ERR_NONE)
                v.code = hdr_err;
            else if (!region_seen[0])
                v.code = ERR_ROOT_CL_ZERO;
            else if (!region_seen[1])
                v.code = ERR_ROOT_PQ_ZERO;
            else if (!region_seen[2])
                v.code = ERR_DEV_CL_ZERO;
            else if (!region_seen[3])
                v.code = ERR_DEV_PQ_ZERO;
            else if (!keys_differ)
                v.code = ERR_KEYS_EQUAL;
            else
                v.code = ERR_NONE;
            v.ok = (v.code == ERR_NONE);
            expected_verdicts.push_back(v);
            rec_pos     = 0;
            region_seen = '0;
            keys_differ = 1'b0;
            hdr_err     = ERR_NONE;
        end
    endfunction

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_record <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        judge_byte(b, last);
        bytes_sent++;
    endtask

    // Drop valid and hold off until every verdict has come back
    task automatic drain_requests;
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_VERSION:   hdr_cfg.version   = value;
            REG_ROOT_ALG:  hdr_cfg.root_alg  = value;
            REG_DEV_SUITE: hdr_cfg.dev_suite = value;
            default:       ;
        endcase
        cfg_writes++;
    endtask

    task automatic set_header_regs(input logic [7:0] v, input logic [7:0] r,
                                   input logic [7:0] d);
        drain_requests();
        write_reg(REG_VERSION, v);
        write_reg(REG_ROOT_ALG, r);
        write_reg(REG_DEV_SUITE, d);
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Position of interest in a region: either end or anywhere
    function automatic int unsigned pick_spot(input int unsigned n);
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    function automatic void fill_key_region(input int unsigned n, input logic zero,
                                            input logic sparse);
        int unsigned spot;
        spot = pick_spot(n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (zero)
                rec_bytes.push_back(8'h00);
            else if (sparse)
                rec_bytes.push_back((i == spot) ? 8'($urandom_range(1, 255)) : 8'h00);
            else
                rec_bytes.push_back(8'($urandom));
        end
    endfunction

    // Build a record of the given shape, cut or pad it to len bytes, and send it
    task automatic send_record(input rec_shape_t shape, input int unsigned len);
        int unsigned spot;
        rec_bytes.delete();
        rec_bytes.push_back(shape.bad_version ?
                            hdr_cfg.version ^ 8'($urandom_range(1, 255)) : hdr_cfg.version);
        rec_bytes.push_back(shape.bad_root_alg ?
                            hdr_cfg.root_alg ^ 8'($urandom_range(1, 255)) :
                            hdr_cfg.root_alg);
        fill_key_region(CLASSIC_KEY_BYTES, shape.zero_region[0], shape.sparse);
        fill_key_region(ROOT_PQ_BYTES, shape.zero_region[1], shape.sparse);
        rec_bytes.push_back(shape.bad_dev_suite ?
                            hdr_cfg.dev_suite ^ 8'($urandom_range(1, 255)) :
                            hdr_cfg.dev_suite);

        // Device classical key: a copy of the root key, differing in one byte unless equal, or all zero
        spot = pick_spot(CLASSIC_KEY_BYTES);
        for (int unsigned i = 0; i < CLASSIC_KEY_BYTES; i++)
        begin
            if (shape.zero_region[2])
                rec_bytes.push_back(8'h00);
            else if (!shape.keys_equal && i == spot)
                rec_bytes.push_back(rec_bytes[OFF_ROOT_CL + i] ^ 8'($urandom_range(1, 255)));
            else
                rec_bytes.push_back(rec_bytes[OFF_ROOT_CL + i]);
        end
        fill_key_region(DEVICE_PQ_BYTES, shape.zero_region[3], shape.sparse);

        while (rec_bytes.size() > len)
            void'(rec_bytes.pop_back());
        while (rec_bytes.size() < len)
            rec_bytes.push_back(8'($urandom));

        foreach (rec_bytes[i])
            send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
        records_sent++;
        if (len == RECORD_LEN)
            full_records++;
    endtask

    function automatic rec_shape_t random_shape();
        rec_shape_t s;
        s.bad_version    = ($urandom_range(0, 99) < 8);
        s.bad_root_alg   = ($urandom_range(0, 99) < 8);
        s.bad_dev_suite  = ($urandom_range(0, 99) < 8);
        for (int r = 0; r < 4; r++)
            s.zero_region[r] = ($urandom_range(0, 99) < 6);
        s.keys_equal     = ($urandom_range(0, 99) < 8);
        s.sparse         = ($urandom_range(0, 99) < 25);
        return s;
    endfunction

    task automatic test_good_records;
        rec_shape_t s;
        s = '0;
        send_record(s, RECORD_LEN);
        s.sparse = 1'b1;
        send_record(s, RECORD_LEN);
    endtask

    // Each header byte wrong on its own, then together to check priority
    task automatic test_header_checks;
        rec_shape_t s;
        s = '0;
        s.bad_version = 1'b1;
        send_record(s, RECORD_LEN);
        s = '0;
        s.bad_root_alg = 1'b1;
        send_record(s, RECORD_LEN);
        s = '0;
        s.bad_dev_suite = 1'b1;
        send_record(s, RECORD_LEN);
        s.bad_root_alg = 1'b1;
        send_record(s, RECORD_LEN);
        s.bad_version = 1'b1;
        send_record(s, RECORD_LEN);
    endtask

    task automatic test_empty_key_regions;
        rec_shape_t s;
        for (int r = 0; r < 4; r++)
        begin
            s = '0;
            s.zero_region[r] = 1'b1;
            send_record(s, RECORD_LEN);
        end
        // Header faults outrank empty regions
        s = '0;
        s.zero_region   = '1;
        s.bad_dev_suite = 1'b1;
        send_record(s, RECORD_LEN);
        s = '0;
        s.sparse         = 1'b1;
        s.zero_region[3] = 1'b1;
        send_record(s, RECORD_LEN);
    endtask

    task automatic test_key_comparison;
        rec_shape_t s;
        s = '0;
        s.keys_equal = 1'b1;
        send_record(s, RECORD_LEN);
        // An empty region outranks equal keys
        s.zero_region[3] = 1'b1;
        send_record(s, RECORD_LEN);
        s = '0;
        s.sparse = 1'b1;
        send_record(s, RECORD_LEN);
    endtask

    task automatic test_record_length;
        rec_shape_t s;
        s = '0;
        send_record(s, 1);
        send_record(s, 2);
        send_record(s, RECORD_LEN - 1);
        send_record(s, RECORD_LEN + 1);
        // Length outranks a header fault
        s.bad_version = 1'b1;
        send_record(s, 40);
        // Run far past the end, then check the next record is judged afresh
        s = '0;
        send_record(s, OVERRUN_LEN);
        send_record(s, RECORD_LEN);
    endtask

    task automatic test_header_config;
        rec_shape_t s;
        set_header_regs(8'h00, 8'hFF, 8'h00);
        s = '0;
        send_record(s, RECORD_LEN);
        s.bad_root_alg = 1'b1;
        send_record(s, RECORD_LEN);
        // A write to the spare index must leave the headers alone
        drain_requests();
        write_reg(REG_SPARE, 8'h5A);
        s = '0;
        send_record(s, RECORD_LEN);
        set_header_regs(8'hFF, 8'h00, 8'hFF);
        s.bad_dev_suite = 1'b1;
        send_record(s, RECORD_LEN);
    endtask

    // Full records with random faults, mixed with short and near-length noise
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int full_pct, input int n_records);
        int unsigned len;
        int          pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        set_header_regs(pick_reg_value(), pick_reg_value(), pick_reg_value());
        for (int n = 0; n < n_records; n++)
        begin
            if (n % 8 == 7)
                set_header_regs(pick_reg_value(), pick_reg_value(), pick_reg_value());
            else if ($urandom_range(0, 9) == 0)
                drain_requests();
            pick = $urandom_range(0, 99);
            if (pick < full_pct)
                len = RECORD_LEN;
            else if (pick < full_pct + full_pct / 4)
                len = RECORD_LEN - 3 + $urandom_range(0, 6);
            else
                len = $urandom_range(1, 48);
            send_record(random_shape(), len);
        end
    endtask

    // Compare each taken verdict with the oldest prediction and set the next stall
    always @(posedge clk)
    begin : check_verdicts
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("verdict ok=%0b code=%0d with none pending",
                                          record_ok, error_code));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (record_ok !== want.ok)
                    report_mismatch($sformatf("record_ok %b, expected %b",
                                              record_ok, want.ok));
                if (error_code !== want.code)
                    report_mismatch($sformatf("error_code %0d, expected %0d (%s)",
                                              error_code, want.code, want.code.name()));
                verdicts_checked++;
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles with %0d verdicts outstanding",
                     cycle_count, expected_verdicts.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        hdr_cfg     = {RST_VERSION, RST_ROOT_ALG, RST_DEV_SUITE};
        rec_pos     = 0;
        region_seen = '0;
        keys_differ = 1'b0;
        hdr_err     = ERR_NONE;
        foreach (root_key_copy[k])
            root_key_copy[k] = 8'h00;
        send_idle_pct = 12;
        recv_idle_pct = 86;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_good_records();
        test_header_checks();
        test_empty_key_regions();
        test_key_comparison();
        test_record_length();
        test_header_config();
        test_random_traffic(12, 86, 50, 24);
        test_random_traffic(86, 12, 8, 24);
        test_random_traffic(0, 0, 50, 24);

        drain_requests();
        repeat (8) @(posedge clk);

        $display("Run covered %0d records (%0d of full length) in %0d bytes, %0d verdicts checked,",
                 records_sent, full_records, bytes_sent, verdicts_checked);
        $display("with %0d register writes across three idling regimes.", cfg_writes);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### files.f
rtl/hkrv_pkg.sv
rtl/hkrv_core.sv
rtl/hybrid_key_record_validator_unit.sv
sim/hybrid_key_record_validator_unit_test.sv
